>>> rtl/ecm_pkg.sv
// shared types, constants and coefficient tables of the crossfade mixer
package ecm_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int GAIN_BITS_DEF    = 16;
    localparam int RAMP_BITS_DEF    = 24;

    // quarter-turn phase fraction bits, one quotient bit per divider step
    localparam int PHASE_BITS   = 30;
    localparam int HORNER_STEPS = 6;
    localparam int CNT_REG_W    = 4;
    localparam int CNT_W        = CNT_REG_W + 1;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_LOAD,
        OP_TH,
        OP_TSQ,
        OP_H1,
        OP_H2,
        OP_H3,
        OP_SIN,
        OP_GAIN,
        OP_MULT,
        OP_SUM,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel_b;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic h_last;
        logic chan_zero;
        logic out_full;
    } t_status;

    // divisors of the taylor horner steps
    function automatic logic [7:0] horner_div(input logic [2:0] idx);
        logic [7:0] d;
        case (idx)
            3'd0:    d = 8'd156;
            3'd1:    d = 8'd110;
            3'd2:    d = 8'd72;
            3'd3:    d = 8'd42;
            3'd4:    d = 8'd20;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor), the estimate is low by at most one
    function automatic logic [29:0] horner_recip(input logic [2:0] idx);
        logic [29:0] r;
        case (idx)
            3'd0:    r = 30'd27531841;
            3'd1:    r = 30'd39045157;
            3'd2:    r = 30'd59652323;
            3'd3:    r = 30'd102261126;
            3'd4:    r = 30'd214748364;
            default: r = 30'd715827882;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/ecm_div.sv
// restoring divider producing the ramp phase fraction one bit per cycle
module ecm_div #(
    parameter int RAMP_BITS = ecm_pkg::RAMP_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [RAMP_BITS:0]                  i_num,
    input  logic [RAMP_BITS:0]                  i_den,
    output logic                                o_busy,
    output logic [ecm_pkg::PHASE_BITS-1:0]      o_quot
);

    localparam int RW = RAMP_BITS + 2;
    localparam int PB = ecm_pkg::PHASE_BITS;
    localparam int CW = $clog2(PB + 1);

    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_den;
    logic [PB-1:0] r_quot;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    logic [RW-1:0] shifted;
    logic          ge;

    always_comb begin
        shifted = {r_rem[RW-2:0], 1'b0};
        ge      = (shifted >= r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(PB);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= {1'b0, i_den};
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? (shifted - r_den) : shifted;
            r_quot <= {r_quot[PB-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

>>> rtl/ecm_dp.sv
// datapath: frame counters, gain sine unit, mixer, rounding and output register
module ecm_dp #(
    parameter int MAX_CHANNELS = ecm_pkg::MAX_CHANNELS_DEF,
    parameter int GAIN_BITS    = ecm_pkg::GAIN_BITS_DEF,
    parameter int RAMP_BITS    = ecm_pkg::RAMP_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ecm_pkg::t_cmd                     i_cmd,
    output ecm_pkg::t_status                  o_status,
    input  logic signed [15:0]                i_sample_a,
    input  logic signed [15:0]                i_sample_b,
    input  logic                              i_last,
    input  logic [RAMP_BITS-1:0]              i_ramp_len_a,
    input  logic [RAMP_BITS-1:0]              i_ramp_len_b,
    input  logic [RAMP_BITS-1:0]              i_start_index_a,
    input  logic [RAMP_BITS-1:0]              i_start_index_b,
    input  logic [ecm_pkg::CNT_REG_W-1:0]     i_channel_count,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [15:0]                o_mixed_sample,
    output logic                              o_clipped
);

    localparam int RB    = RAMP_BITS;
    localparam int GW    = GAIN_BITS + 1;
    localparam int PW    = GW + 17;
    localparam int VW    = PW + 1;
    localparam int RNDW  = VW - GAIN_BITS;
    localparam int CNW   = ecm_pkg::CNT_W;
    localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PB    = ecm_pkg::PHASE_BITS;

    localparam logic [32:0]   G_ROUND  = 33'(1) << (29 - GAIN_BITS);
    localparam logic [32:0]   G_MAX    = 33'(1) << GAIN_BITS;
    localparam logic [VW-1:0] MIX_HALF = VW'(1) << (GAIN_BITS - 1);
    localparam logic [CNW-1:0] MAXC    = CNW'(MAX_CHANNELS);
    localparam logic [RB-1:0] FRAME_MAX = {RB{1'b1}};

    // stream and counter state
    logic signed [15:0] r_a, r_b;
    logic               r_last;
    logic [RB-1:0]      r_frame;
    logic [POS_W-1:0]   r_pos;

    // gain unit state
    logic [30:0]        r_th;
    logic [31:0]        r_t;
    logic [30:0]        r_acc;
    logic [31:0]        r_p;
    logic [29:0]        r_qe;
    logic [2:0]         r_hidx;
    logic [31:0]        r_s;
    logic [GW-1:0]      r_gain_out, r_gain_in;

    // mixer state
    logic signed [PW-1:0] r_pa, r_pb;
    logic signed [VW-1:0] r_v;
    logic                 r_out_valid;
    logic signed [15:0]   r_mixed;
    logic                 r_clipped;

    // ramp index and phase division operands
    logic [RB-1:0] len, start, n, k;
    logic [RB:0]   sum, num, den;
    logic          div_busy;
    logic [PB-1:0] quot;

    always_comb begin
        len   = i_cmd.sel_b ? i_ramp_len_b : i_ramp_len_a;
        start = i_cmd.sel_b ? i_start_index_b : i_start_index_a;
        n     = (len == '0) ? RB'(1) : len;
        sum   = {1'b0, start} + {1'b0, r_frame};
        k     = (sum >= {1'b0, n}) ? (n - RB'(1)) : sum[RB-1:0];
        // cosine of track a taken as the sine of the mirrored phase
        num   = i_cmd.sel_b ? ({k, 1'b0} + (RB+1)'(1)) : ({n - k, 1'b0} - (RB+1)'(1));
        den   = {n, 1'b0};
    end

    ecm_div #(
        .RAMP_BITS (RAMP_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == ecm_pkg::OP_LOAD),
        .i_num   (num),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    // sine unit arithmetic, one multiplier per operation
    logic [60:0] th_prod;
    logic [61:0] t_prod, p_prod, q_prod, s_prod;
    logic [37:0] qd_prod;
    logic [7:0]  hdiv;
    logic [31:0] hrem;
    logic [30:0] hx;
    logic [30:0] acc_nx;
    logic [32:0] g_sum, g_sh, g_cap;

    always_comb begin
        th_prod = {31'b0, quot} * {30'b0, ecm_pkg::HALF_PI_Q30};
        t_prod  = {31'b0, r_th} * {31'b0, r_th};
        p_prod  = {30'b0, r_t} * {31'b0, r_acc};
        q_prod  = {30'b0, r_p} * {32'b0, ecm_pkg::horner_recip(r_hidx)};
        hdiv    = ecm_pkg::horner_div(r_hidx);
        qd_prod = {8'b0, r_qe} * {30'b0, hdiv};
        hrem    = r_p - qd_prod[31:0];
        hx      = {1'b0, r_qe} + ((hrem >= {24'b0, hdiv}) ? 31'd1 : 31'd0);
        acc_nx  = (hx >= ecm_pkg::Q30_ONE) ? 31'd0 : (ecm_pkg::Q30_ONE - hx);
        s_prod  = {31'b0, r_th} * {31'b0, r_acc};
        g_sum   = {1'b0, r_s} + G_ROUND;
        g_sh    = g_sum >> (30 - GAIN_BITS);
        g_cap   = (g_sh > G_MAX) ? G_MAX : g_sh;
    end

    // rounding and saturation of the mix
    logic          neg;
    logic [VW-1:0] mag, mag_r;
    logic [RNDW-1:0] rnd;
    logic          clip;
    logic [15:0]   res;

    always_comb begin
        neg   = r_v[VW-1];
        mag   = neg ? VW'(-r_v) : VW'(r_v);
        mag_r = mag + MIX_HALF;
        rnd   = mag_r[VW-1:GAIN_BITS];
        if (neg) begin
            clip = (rnd > RNDW'(32768));
            res  = clip ? 16'h8000 : (~rnd[15:0] + 16'd1);
        end else begin
            clip = (rnd > RNDW'(32767));
            res  = clip ? 16'h7fff : rnd[15:0];
        end
    end

    // channel count clamp and position advance
    logic [CNW-1:0] chans, pos_nx;

    always_comb begin
        if (i_channel_count == '0) begin
            chans = CNW'(1);
        end else if ({1'b0, i_channel_count} > MAXC) begin
            chans = MAXC;
        end else begin
            chans = {1'b0, i_channel_count};
        end
        pos_nx = CNW'(r_pos) + CNW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame     <= '0;
            r_pos       <= '0;
            r_gain_out  <= '0;
            r_gain_in   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                ecm_pkg::OP_GAIN: begin
                    if (i_cmd.sel_b) begin
                        r_gain_in <= g_cap[GW-1:0];
                    end else begin
                        r_gain_out <= g_cap[GW-1:0];
                    end
                end
                ecm_pkg::OP_OUT: begin
                    r_out_valid <= 1'b1;
                    if (r_last) begin
                        r_frame <= '0;
                        r_pos   <= '0;
                    end else if (pos_nx >= chans) begin
                        r_pos <= '0;
                        if (r_frame != FRAME_MAX) begin
                            r_frame <= r_frame + RB'(1);
                        end
                    end else begin
                        r_pos <= pos_nx[POS_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ecm_pkg::OP_TAKE: begin
                r_a    <= i_sample_a;
                r_b    <= i_sample_b;
                r_last <= i_last;
            end
            ecm_pkg::OP_TH:   r_th <= th_prod[60:30];
            ecm_pkg::OP_TSQ: begin
                r_t    <= t_prod[61:30];
                r_acc  <= ecm_pkg::Q30_ONE;
                r_hidx <= '0;
            end
            ecm_pkg::OP_H1:   r_p  <= p_prod[61:30];
            ecm_pkg::OP_H2:   r_qe <= q_prod[61:32];
            ecm_pkg::OP_H3: begin
                r_acc  <= acc_nx;
                r_hidx <= r_hidx + 3'd1;
            end
            ecm_pkg::OP_SIN:  r_s <= s_prod[61:30];
            ecm_pkg::OP_MULT: begin
                r_pa <= PW'(r_a * $signed({1'b0, r_gain_out}));
                r_pb <= PW'(r_b * $signed({1'b0, r_gain_in}));
            end
            ecm_pkg::OP_SUM:  r_v <= VW'(r_pa) + VW'(r_pb);
            ecm_pkg::OP_OUT: begin
                r_mixed   <= res;
                r_clipped <= clip;
            end
            default: begin
            end
        endcase
    end

    assign o_status.div_busy  = div_busy;
    assign o_status.h_last    = (r_hidx == 3'(ecm_pkg::HORNER_STEPS - 1));
    assign o_status.chan_zero = (r_pos == '0);
    assign o_status.out_full  = r_out_valid;

    assign o_out_valid    = r_out_valid;
    assign o_mixed_sample = r_mixed;
    assign o_clipped      = r_clipped;

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (33'(r_gain_out) <= G_MAX) && (33'(r_gain_in) <= G_MAX))
        else $error("gain above unity");

    a_div_idle_at_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ecm_pkg::OP_OUT) |-> !div_busy)
        else $error("phase divider busy while a word is written");

    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ecm_pkg::OP_OUT) |=> r_out_valid)
        else $error("result word lost");

    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_clipped) |-> (r_mixed == 16'sh7fff || r_mixed == 16'sh8000))
        else $error("clip flag without saturated value");

endmodule

>>> rtl/ecm_ctrl.sv
// controller: sequences the gain computation per frame and the mix per word
module ecm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ecm_pkg::t_status i_status,
    output ecm_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_TH,
        ST_TSQ,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_SIN,
        ST_GAIN,
        ST_MULT,
        ST_SUM,
        ST_OUT
    } t_state;

    t_state r_state;
    logic   r_sel_b;

    always_comb begin
        o_cmd.sel_b = r_sel_b;
        case (r_state)
            ST_IDLE: o_cmd.op = i_in_valid ? ecm_pkg::OP_TAKE : ecm_pkg::OP_NONE;
            ST_LOAD: o_cmd.op = ecm_pkg::OP_LOAD;
            ST_TH:   o_cmd.op = ecm_pkg::OP_TH;
            ST_TSQ:  o_cmd.op = ecm_pkg::OP_TSQ;
            ST_H1:   o_cmd.op = ecm_pkg::OP_H1;
            ST_H2:   o_cmd.op = ecm_pkg::OP_H2;
            ST_H3:   o_cmd.op = ecm_pkg::OP_H3;
            ST_SIN:  o_cmd.op = ecm_pkg::OP_SIN;
            ST_GAIN: o_cmd.op = ecm_pkg::OP_GAIN;
            ST_MULT: o_cmd.op = ecm_pkg::OP_MULT;
            ST_SUM:  o_cmd.op = ecm_pkg::OP_SUM;
            ST_OUT:  o_cmd.op = i_status.out_full ? ecm_pkg::OP_NONE : ecm_pkg::OP_OUT;
            default: o_cmd.op = ecm_pkg::OP_NONE;
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sel_b <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_sel_b <= 1'b0;
                        // gains are refreshed on the first channel of a frame
                        r_state <= i_status.chan_zero ? ST_LOAD : ST_MULT;
                    end
                end
                ST_LOAD: r_state <= ST_DIV;
                ST_DIV: begin
                    if (!i_status.div_busy) begin
                        r_state <= ST_TH;
                    end
                end
                ST_TH:   r_state <= ST_TSQ;
                ST_TSQ:  r_state <= ST_H1;
                ST_H1:   r_state <= ST_H2;
                ST_H2:   r_state <= ST_H3;
                ST_H3:   r_state <= i_status.h_last ? ST_SIN : ST_H1;
                ST_SIN:  r_state <= ST_GAIN;
                ST_GAIN: begin
                    if (r_sel_b) begin
                        r_state <= ST_MULT;
                    end else begin
                        r_sel_b <= 1'b1;
                        r_state <= ST_LOAD;
                    end
                end
                ST_MULT: r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_OUT;
                ST_OUT: begin
                    if (!i_status.out_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_div_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_busy |-> (r_state == ST_DIV))
        else $error("divider running outside its wait state");

    a_load_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |=> (i_status.div_busy && r_state == ST_DIV))
        else $error("phase division did not start");

    a_b_after_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MULT && $past(r_state) == ST_GAIN) |-> r_sel_b)
        else $error("mix started before the fade-in gain");

endmodule

>>> rtl/equal_power_crossfade_mixer.sv
// equal-power crossfade mixer: register file, controller and datapath
// after a word is accepted it passes the mult, sum and out states and then the output register; the first
//   channel of a frame first computes two gains
// a new word is accepted only once the last one has left the out state; each gain waits on
//   the 30-step phase divider, runs six horner steps of three states each (h1, h2, h3)
//   and five further steps (load, th, tsq, sin, gain); a stalled output word holds the controller
// reset: synchronous active low; registers return to ramp lengths 1, starts 0, 2 channels
module equal_power_crossfade_mixer #(
    parameter int MAX_CHANNELS = ecm_pkg::MAX_CHANNELS_DEF,
    parameter int GAIN_BITS    = ecm_pkg::GAIN_BITS_DEF,
    parameter int RAMP_BITS    = ecm_pkg::RAMP_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_a [15:0], sample_b [31:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // mixed_sample [15:0]
    output logic [0:0]  m_axis_tuser    // clipped [0]
);

    localparam logic [2:0] REG_RAMP_LEN_A    = 3'd0;
    localparam logic [2:0] REG_RAMP_LEN_B    = 3'd1;
    localparam logic [2:0] REG_START_INDEX_A = 3'd2;
    localparam logic [2:0] REG_START_INDEX_B = 3'd3;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd4;

    logic [RAMP_BITS-1:0]          r_ramp_len_a, r_ramp_len_b;
    logic [RAMP_BITS-1:0]          r_start_index_a, r_start_index_b;
    logic [ecm_pkg::CNT_REG_W-1:0] r_channel_count;

    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_len_a    <= RAMP_BITS'(1);
            r_ramp_len_b    <= RAMP_BITS'(1);
            r_start_index_a <= '0;
            r_start_index_b <= '0;
            r_channel_count <= ecm_pkg::CNT_REG_W'(2);
        end else if (wr_en) begin
            case (reg_idx)
                REG_RAMP_LEN_A:    r_ramp_len_a    <= pwdata[RAMP_BITS-1:0];
                REG_RAMP_LEN_B:    r_ramp_len_b    <= pwdata[RAMP_BITS-1:0];
                REG_START_INDEX_A: r_start_index_a <= pwdata[RAMP_BITS-1:0];
                REG_START_INDEX_B: r_start_index_b <= pwdata[RAMP_BITS-1:0];
                REG_CHANNEL_COUNT: r_channel_count <= pwdata[ecm_pkg::CNT_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RAMP_LEN_A:    prdata = 32'(r_ramp_len_a);
            REG_RAMP_LEN_B:    prdata = 32'(r_ramp_len_b);
            REG_START_INDEX_A: prdata = 32'(r_start_index_a);
            REG_START_INDEX_B: prdata = 32'(r_start_index_b);
            REG_CHANNEL_COUNT: prdata = 32'(r_channel_count);
            default:           prdata = '0;
        endcase
    end

    ecm_pkg::t_cmd    cmd;
    ecm_pkg::t_status status;

    ecm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ecm_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .GAIN_BITS    (GAIN_BITS),
        .RAMP_BITS    (RAMP_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_sample_a      (s_axis_tdata[15:0]),
        .i_sample_b      (s_axis_tdata[31:16]),
        .i_last          (s_axis_tlast),
        .i_ramp_len_a    (r_ramp_len_a),
        .i_ramp_len_b    (r_ramp_len_b),
        .i_start_index_a (r_start_index_a),
        .i_start_index_b (r_start_index_b),
        .i_channel_count (r_channel_count),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_mixed_sample  (m_axis_tdata),
        .o_clipped       (m_axis_tuser[0])
    );

endmodule
